// ----- hw/rtl/mlfq_pkg.sv -----
// Package for the multilevel feedback queue scheduler.
// It holds the slot states, the event codes and the default constants.
// No dependencies.
package mlfq_pkg;
   localparam int unsigned MAX_TASKS_DEF = 16;
   localparam logic [15:0] TIMEOUT_RESET = 16'd20;

   typedef enum logic [2:0] {
      ST_EMPTY     = 3'd0,
      ST_READY     = 3'd1,
      ST_RUNNING   = 3'd2,
      ST_SUSPENDED = 3'd3,
      ST_COMPLETED = 3'd4,
      ST_TIMEOUT   = 3'd5
   } slot_st_type;

   typedef enum logic [2:0] {
      EV_STARTED   = 3'd0,
      EV_RUNNING   = 3'd1,
      EV_TIMEOUT   = 3'd2,
      EV_COMPLETED = 3'd3,
      EV_SUSPENDED = 3'd4
   } event_type;
endpackage

// ----- hw/rtl/mlfq_ram.sv -----
// Generic single-port-write RAM with one registered read port.
// No dependencies.
module mlfq_ram #(
   parameter int unsigned WIDTH = 4,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/mlfq_task_scheduler.sv -----
// Four-level feedback queue scheduler over task slots, one sequencer.
// An arrive beat is taken in the idle state; a tick makes one timeout pass over
// the slots, one slot a cycle while no event is held up, plus, when the runner
// does not continue, a queue skip pass through the fifo RAM, and it stalls while
// rsp_ready is low. One item at a time. Synchronous active-high reset empties all
// slots and queues, clears the tick count and sets timeout_limit to 20.
module mlfq_task_scheduler #(
   parameter int unsigned MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [3:0]  req_task_slot,
   input  logic [1:0]  req_base_level,
   input  logic [9:0]  req_burst_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [3:0]  rsp_event_slot,
   output logic [15:0] rsp_event_time,
   output logic [1:0]  rsp_event_level,
   output logic [9:0]  rsp_event_remaining,
   output logic        rsp_last_of_tick,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_limit
);
   localparam int unsigned SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int unsigned FW = $clog2(MAX_TASKS + 1);
   localparam int unsigned AW = SW + 2;
   localparam int unsigned EW = $clog2(MAX_TASKS) + 1;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_POPRD = 10'b0000000010,
      S_POPCK = 10'b0000000100,
      S_RUNEV = 10'b0000001000,
      S_SCAN  = 10'b0000010000,
      S_START = 10'b0000100000,
      S_END   = 10'b0001000000,
      S_OUT   = 10'b0010000000,
      S_PUSH  = 10'b0100000000,
      S_LAST  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in, ret_ff;

   logic [15:0] limit_ff, tick_ff;
   mlfq_pkg::slot_st_type status_ff [MAX_TASKS];
   logic [1:0]  base_ff [MAX_TASKS];
   logic [1:0]  cur_ff  [MAX_TASKS];
   logic [9:0]  rem_ff  [MAX_TASKS];
   logic [15:0] wait_ff [MAX_TASKS];
   logic [SW-1:0] head_ff [4];
   logic [FW-1:0] fill_ff [4];
   logic          run_v_ff;
   logic [SW-1:0] run_ff;
   logic          cont_ff;
   logic [1:0]    lvl_ff;
   logic [SW:0]   idx_ff;

   logic          pd_v_ff;
   mlfq_pkg::event_type pd_res_ff;
   logic [3:0]    pd_slot_ff;
   logic [15:0]   pd_time_ff;
   logic [1:0]    pd_lvl_ff;
   logic [9:0]    pd_rem_ff;

   logic          ob_v_ff;
   logic [2:0]    ob_res_ff;
   logic [3:0]    ob_slot_ff;
   logic [15:0]   ob_time_ff;
   logic [1:0]    ob_lvl_ff;
   logic [9:0]    ob_rem_ff;
   logic          ob_last_ff;

   // fifo RAM
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [3:0]    wr_data, rd_data;
   logic [SW-1:0] tail;

   mlfq_ram #(.WIDTH(4), .DEPTH(4 * MAX_TASKS)) u_fifo (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic          arrive;
   logic [SW-1:0] aslot;
   logic          aslot_ok;
   logic [SW-1:0] e_slot;
   logic          e_ok;
   logic [SW-1:0] sidx;
   logic          s_wait, s_to;
   logic [15:0]   tnext;
   logic [1:0]    dem_lvl;
   logic          push_tick;
   logic          scan_done;
   logic          gen_ok;
   logic          gen_fire;

   function automatic logic [SW-1:0] inc_wrap(input logic [SW-1:0] v);
      logic [SW-1:0] r;
      r = (v == SW'(MAX_TASKS - 1)) ? '0 : v + SW'(1);
      return r;
   endfunction

   function automatic logic [AW-1:0] fifo_addr(input logic [1:0] l, input logic [SW-1:0] p);
      logic [AW-1:0] a;
      a = AW'(l) * AW'(MAX_TASKS) + AW'(p);
      return a;
   endfunction

   function automatic logic [SW-1:0] tail_of(input logic [SW-1:0] h, input logic [FW-1:0] f);
      logic [EW-1:0] sum;
      sum = EW'(h) + EW'(f);
      if (sum >= EW'(MAX_TASKS)) begin
         sum = sum - EW'(MAX_TASKS);
      end
      return sum[SW-1:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign arrive    = req_valid && req_ready && !req_kind;
   assign aslot     = SW'(req_task_slot);
   assign aslot_ok  = (7'(req_task_slot) < 7'(MAX_TASKS))
                      && (status_ff[aslot] == mlfq_pkg::ST_EMPTY
                          || status_ff[aslot] == mlfq_pkg::ST_COMPLETED)
                      && (fill_ff[req_base_level] < FW'(MAX_TASKS));
   assign e_ok      = (7'(rd_data) < 7'(MAX_TASKS));
   assign e_slot    = SW'(rd_data);
   assign sidx      = idx_ff[SW-1:0];
   assign s_wait    = !(run_v_ff && sidx == run_ff)
                      && (status_ff[sidx] == mlfq_pkg::ST_READY
                          || status_ff[sidx] == mlfq_pkg::ST_SUSPENDED);
   assign s_to      = s_wait && ((tick_ff - wait_ff[sidx]) >= limit_ff);
   assign tnext     = tick_ff + 16'd1;
   assign dem_lvl   = (cur_ff[run_ff] == 2'd3) ? 2'd3 : cur_ff[run_ff] + 2'd1;
   assign push_tick = (state_ff == S_PUSH);
   assign scan_done = (idx_ff == (SW+1)'(MAX_TASKS));
   assign gen_ok    = !pd_v_ff || !ob_v_ff;
   assign gen_fire  = gen_ok && ((state_ff == S_RUNEV)
                                 || (state_ff == S_SCAN && !scan_done && s_to)
                                 || (state_ff == S_START && run_v_ff)
                                 || (state_ff == S_OUT));

   always_comb begin
      tail    = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (arrive && aslot_ok) begin
         tail    = tail_of(head_ff[req_base_level], fill_ff[req_base_level]);
         wr_en   = 1'b1;
         wr_addr = fifo_addr(req_base_level, tail);
         wr_data = 4'(aslot);
      end else if (push_tick) begin
         tail    = tail_of(head_ff[cur_ff[run_ff]], fill_ff[cur_ff[run_ff]]);
         wr_en   = fill_ff[cur_ff[run_ff]] < FW'(MAX_TASKS);
         wr_addr = fifo_addr(cur_ff[run_ff], tail);
         wr_data = 4'(run_ff);
      end
   end

   assign rd_addr = fifo_addr(lvl_ff, head_ff[lvl_ff]);

   assign state_in = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         limit_ff <= mlfq_pkg::TIMEOUT_RESET;
         tick_ff  <= '0;
         run_v_ff <= 1'b0;
         run_ff   <= '0;
         ob_v_ff  <= 1'b0;
         pd_v_ff  <= 1'b0;
         cont_ff  <= 1'b0;
         lvl_ff   <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            status_ff[i] <= mlfq_pkg::ST_EMPTY;
         end
         for (int l = 0; l < 4; l++) begin
            head_ff[l] <= '0;
            fill_ff[l] <= '0;
         end
      end else begin
         if (ob_v_ff && rsp_ready) begin
            ob_v_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_timeout_limit;
         end
         if (gen_fire) begin
            pd_v_ff <= 1'b1;
            if (pd_v_ff) begin
               ob_v_ff    <= 1'b1;
               ob_res_ff  <= pd_res_ff;
               ob_slot_ff <= pd_slot_ff;
               ob_time_ff <= pd_time_ff;
               ob_lvl_ff  <= pd_lvl_ff;
               ob_rem_ff  <= pd_rem_ff;
               ob_last_ff <= 1'b0;
            end
         end
         unique case (state_in)
            S_IDLE: begin
               if (req_valid && !req_kind) begin
                  if (aslot_ok) begin
                     fill_ff[req_base_level] <= fill_ff[req_base_level] + FW'(1);
                     base_ff[aslot]   <= req_base_level;
                     cur_ff[aslot]    <= req_base_level;
                     rem_ff[aslot]    <= req_burst_ticks;
                     wait_ff[aslot]   <= tick_ff;
                     status_ff[aslot] <= mlfq_pkg::ST_READY;
                  end
               end else if (req_valid) begin
                  idx_ff  <= '0;
                  lvl_ff  <= '0;
                  if (run_v_ff && base_ff[run_ff] == 2'd0
                      && status_ff[run_ff] == mlfq_pkg::ST_RUNNING) begin
                     cont_ff  <= 1'b1;
                     state_ff <= S_RUNEV;
                  end else begin
                     cont_ff  <= 1'b0;
                     run_v_ff <= 1'b0;
                     state_ff <= S_POPRD;
                  end
               end
            end
            S_POPRD: begin
               if (fill_ff[lvl_ff] != '0) begin
                  state_ff <= S_POPCK;
               end else if (lvl_ff == 2'd3) begin
                  state_ff <= S_SCAN;
               end else begin
                  lvl_ff <= lvl_ff + 2'd1;
               end
            end
            S_POPCK: begin
               head_ff[lvl_ff] <= inc_wrap(head_ff[lvl_ff]);
               fill_ff[lvl_ff] <= fill_ff[lvl_ff] - FW'(1);
               state_ff        <= S_POPRD;
               if (e_ok) begin
                  if (status_ff[e_slot] == mlfq_pkg::ST_READY
                      || status_ff[e_slot] == mlfq_pkg::ST_SUSPENDED) begin
                     run_v_ff <= 1'b1;
                     run_ff   <= e_slot;
                     state_ff <= S_SCAN;
                  end else if (status_ff[e_slot] == mlfq_pkg::ST_TIMEOUT) begin
                     status_ff[e_slot] <= mlfq_pkg::ST_EMPTY;
                  end
               end
            end
            S_RUNEV: begin
               if (gen_ok) begin
                  pd_res_ff  <= mlfq_pkg::EV_RUNNING;
                  pd_slot_ff <= 4'(run_ff);
                  pd_time_ff <= tick_ff;
                  pd_lvl_ff  <= cur_ff[run_ff];
                  pd_rem_ff  <= rem_ff[run_ff];
                  if (rem_ff[run_ff] != '0) begin
                     rem_ff[run_ff] <= rem_ff[run_ff] - 10'd1;
                  end
                  wait_ff[run_ff] <= tnext;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan_done) begin
                  state_ff <= cont_ff ? S_END : S_START;
               end else if (s_to) begin
                  if (gen_ok) begin
                     pd_res_ff  <= mlfq_pkg::EV_TIMEOUT;
                     pd_slot_ff <= 4'(sidx);
                     pd_time_ff <= tick_ff;
                     pd_lvl_ff  <= cur_ff[sidx];
                     pd_rem_ff  <= rem_ff[sidx];
                     status_ff[sidx] <= mlfq_pkg::ST_TIMEOUT;
                     idx_ff     <= idx_ff + (SW+1)'(1);
                  end
               end else begin
                  idx_ff <= idx_ff + (SW+1)'(1);
               end
            end
            S_START: begin
               if (!run_v_ff) begin
                  state_ff <= S_END;
               end else if (gen_ok) begin
                  pd_res_ff  <= mlfq_pkg::EV_STARTED;
                  pd_slot_ff <= 4'(run_ff);
                  pd_time_ff <= tick_ff;
                  pd_lvl_ff  <= cur_ff[run_ff];
                  pd_rem_ff  <= rem_ff[run_ff];
                  status_ff[run_ff] <= mlfq_pkg::ST_RUNNING;
                  if (rem_ff[run_ff] != '0) begin
                     rem_ff[run_ff] <= rem_ff[run_ff] - 10'd1;
                  end
                  wait_ff[run_ff] <= tnext;
                  state_ff <= S_END;
               end
            end
            S_END: begin
               tick_ff <= tnext;
               if (run_v_ff && rem_ff[run_ff] == '0) begin
                  status_ff[run_ff] <= mlfq_pkg::ST_COMPLETED;
                  run_v_ff  <= 1'b0;
                  ret_ff    <= S_LAST;
                  state_ff  <= S_OUT;
               end else if (run_v_ff && base_ff[run_ff] != 2'd0) begin
                  status_ff[run_ff] <= mlfq_pkg::ST_SUSPENDED;
                  cur_ff[run_ff]    <= dem_lvl;
                  ret_ff    <= S_PUSH;
                  state_ff  <= S_OUT;
               end else begin
                  state_ff <= S_LAST;
               end
            end
            S_OUT: begin
               if (gen_ok) begin
                  pd_res_ff  <= (ret_ff == S_PUSH) ? mlfq_pkg::EV_SUSPENDED
                                                   : mlfq_pkg::EV_COMPLETED;
                  pd_slot_ff <= 4'(run_ff);
                  pd_time_ff <= tick_ff;
                  pd_lvl_ff  <= cur_ff[run_ff];
                  pd_rem_ff  <= rem_ff[run_ff];
                  state_ff   <= ret_ff;
               end
            end
            S_PUSH: begin
               if (fill_ff[cur_ff[run_ff]] < FW'(MAX_TASKS)) begin
                  fill_ff[cur_ff[run_ff]] <= fill_ff[cur_ff[run_ff]] + FW'(1);
               end
               run_v_ff <= 1'b0;
               state_ff <= S_LAST;
            end
            S_LAST: begin
               if (!pd_v_ff) begin
                  state_ff <= S_IDLE;
               end else if (!ob_v_ff) begin
                  ob_v_ff    <= 1'b1;
                  ob_res_ff  <= pd_res_ff;
                  ob_slot_ff <= pd_slot_ff;
                  ob_time_ff <= pd_time_ff;
                  ob_lvl_ff  <= pd_lvl_ff;
                  ob_rem_ff  <= pd_rem_ff;
                  ob_last_ff <= 1'b1;
                  pd_v_ff    <= 1'b0;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = ob_v_ff;
   assign rsp_event_res       = ob_res_ff;
   assign rsp_event_slot      = ob_slot_ff;
   assign rsp_event_time      = ob_time_ff;
   assign rsp_event_level     = ob_lvl_ff;
   assign rsp_event_remaining = ob_rem_ff;
   assign rsp_last_of_tick    = ob_last_ff;

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_slot))
      else $error("result overwritten");
`endif
endmodule

// ----- dv/mlfq_checker.sv -----
// Checker for the four-level feedback queue scheduler: watches the request,
// response and csr channels, predicts every event beat and compares.
// Depends on mlfq_pkg for the slot states and event codes.
module mlfq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [3:0]  req_task_slot,
   input  logic [1:0]  req_base_level,
   input  logic [9:0]  req_burst_ticks,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_event_res,
   input  logic [3:0]  rsp_event_slot,
   input  logic [15:0] rsp_event_time,
   input  logic [1:0]  rsp_event_level,
   input  logic [9:0]  rsp_event_remaining,
   input  logic        rsp_last_of_tick,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_timeout_limit,
   output int          fail_count,
   output int          events_pending
);
   typedef struct {
      mlfq_pkg::event_type res;
      logic [3:0]  slot;
      logic [15:0] at;
      logic [1:0]  level;
      logic [9:0]  remaining;
      logic        last;
   } sched_event_type;

   sched_event_type event_q[$];

   logic [15:0] limit_r;
   logic [15:0] tick_r;
   mlfq_pkg::slot_st_type slot_st[16];
   logic [1:0]  slot_base[16];
   logic [1:0]  slot_lvl[16];
   logic [9:0]  slot_left[16];
   logic [15:0] slot_since[16];
   logic [3:0]  level_q[4][$];
   logic        run_v;
   logic [3:0]  runner;
   int          n_ev;

   task automatic push_event(mlfq_pkg::event_type res, logic [3:0] s, logic [15:0] t);
      sched_event_type e;
      e.res = res;
      e.slot = s;
      e.at = t;
      e.level = slot_lvl[s];
      e.remaining = slot_left[s];
      e.last = 1'b0;
      event_q.push_back(e);
      n_ev++;
   endtask

   task automatic scan_timeouts(logic [15:0] t);
      for (int i = 0; i < 16; i++) begin
         if (run_v && i == runner) continue;
         if (slot_st[i] != mlfq_pkg::ST_READY && slot_st[i] != mlfq_pkg::ST_SUSPENDED)
            continue;
         if (16'(t - slot_since[i]) >= limit_r) begin
            slot_st[i] = mlfq_pkg::ST_TIMEOUT;
            push_event(mlfq_pkg::EV_TIMEOUT, 4'(i), t);
         end
      end
   endtask

   task automatic pop_live(int lvl, output logic found, output logic [3:0] s);
      logic [3:0] e;
      found = 1'b0;
      s = '0;
      while (level_q[lvl].size() > 0 && !found) begin
         e = level_q[lvl].pop_front();
         if (slot_st[e] == mlfq_pkg::ST_READY || slot_st[e] == mlfq_pkg::ST_SUSPENDED) begin
            found = 1'b1;
            s = e;
         end else if (slot_st[e] == mlfq_pkg::ST_TIMEOUT) begin
            slot_st[e] = mlfq_pkg::ST_EMPTY;
         end
      end
   endtask

   task automatic run_tick();
      logic [15:0] t;
      logic [15:0] t1;
      logic        cont;
      logic        found;
      logic [3:0]  s;
      t = tick_r;
      n_ev = 0;
      cont = run_v && slot_base[runner] == 2'd0 && slot_st[runner] == mlfq_pkg::ST_RUNNING;
      if (!cont) begin
         run_v = 1'b0;
         for (int l = 0; l < 4 && !run_v; l++) begin
            pop_live(l, found, s);
            if (found) begin
               run_v = 1'b1;
               runner = s;
            end
         end
      end
      if (cont) begin
         push_event(mlfq_pkg::EV_RUNNING, runner, t);
         if (slot_left[runner] > 0) slot_left[runner]--;
         slot_since[runner] = t + 16'd1;
         scan_timeouts(t);
      end else begin
         scan_timeouts(t);
         if (run_v) begin
            slot_st[runner] = mlfq_pkg::ST_RUNNING;
            push_event(mlfq_pkg::EV_STARTED, runner, t);
            if (slot_left[runner] > 0) slot_left[runner]--;
            slot_since[runner] = t + 16'd1;
         end
      end
      t1 = t + 16'd1;
      tick_r = t1;
      if (run_v) begin
         if (slot_left[runner] == 0) begin
            slot_st[runner] = mlfq_pkg::ST_COMPLETED;
            push_event(mlfq_pkg::EV_COMPLETED, runner, t1);
            run_v = 1'b0;
         end else if (slot_base[runner] != 2'd0) begin
            slot_st[runner] = mlfq_pkg::ST_SUSPENDED;
            if (slot_lvl[runner] < 2'd3) slot_lvl[runner]++;
            push_event(mlfq_pkg::EV_SUSPENDED, runner, t1);
            level_q[slot_lvl[runner]].push_back(runner);
            run_v = 1'b0;
         end
      end
      if (n_ev > 0) event_q[event_q.size() - 1].last = 1'b1;
   endtask

   task automatic take_arrival(logic [3:0] s, logic [1:0] bl, logic [9:0] burst);
      if (slot_st[s] != mlfq_pkg::ST_EMPTY && slot_st[s] != mlfq_pkg::ST_COMPLETED) return;
      level_q[bl].push_back(s);
      slot_base[s] = bl;
      slot_lvl[s] = bl;
      slot_left[s] = burst;
      slot_since[s] = tick_r;
      slot_st[s] = mlfq_pkg::ST_READY;
   endtask

   // Handshakes are sampled at the falling edge, where the channels are stable.
   always @(negedge clock) begin
      sched_event_type e;
      if (reset) begin
         fail_count = 0;
         limit_r = mlfq_pkg::TIMEOUT_RESET;
         tick_r = '0;
         run_v = 1'b0;
         runner = '0;
         event_q.delete();
         for (int i = 0; i < 16; i++) slot_st[i] = mlfq_pkg::ST_EMPTY;
         for (int l = 0; l < 4; l++) level_q[l].delete();
      end else begin
         if (csr_valid && csr_ready) limit_r = csr_timeout_limit;
         if (req_valid && req_ready) begin
            if (req_kind) run_tick();
            else take_arrival(req_task_slot, req_base_level, req_burst_ticks);
         end
         if (rsp_valid && rsp_ready) begin
            if (event_q.size() == 0) begin
               $display("%0t: unexpected beat res=%0d slot=%0d", $time,
                        rsp_event_res, rsp_event_slot);
               fail_count++;
            end else begin
               e = event_q.pop_front();
               if (rsp_event_res !== e.res || rsp_event_slot !== e.slot ||
                   rsp_event_time !== e.at || rsp_event_level !== e.level ||
                   rsp_event_remaining !== e.remaining ||
                   rsp_last_of_tick !== e.last) begin
                  $display("%0t: expected res=%0d slot=%0d time=%0d lvl=%0d rem=%0d last=%0d",
                           $time, e.res, e.slot, e.at, e.level, e.remaining, e.last);
                  $display("%0t: actual   res=%0d slot=%0d time=%0d lvl=%0d rem=%0d last=%0d",
                           $time, rsp_event_res, rsp_event_slot, rsp_event_time,
                           rsp_event_level, rsp_event_remaining, rsp_last_of_tick);
                  fail_count++;
               end
            end
         end
      end
      events_pending = event_q.size();
   end
endmodule

// ----- dv/tb_mlfq_task_scheduler.sv -----
// Top of the scheduler testbench: clock, reset, arrive/tick stimulus, csr
// writes and response back-pressure. Depends on mlfq_pkg, the scheduler RTL
// and mlfq_checker, which predicts and compares.
module tb_mlfq_task_scheduler;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [3:0]  req_task_slot;
   logic [1:0]  req_base_level;
   logic [9:0]  req_burst_ticks;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [3:0]  rsp_event_slot;
   logic [15:0] rsp_event_time;
   logic [1:0]  rsp_event_level;
   logic [9:0]  rsp_event_remaining;
   logic        rsp_last_of_tick;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_timeout_limit;
   int          fail_count;
   int          events_pending;
   int          tx_idle_pct;
   int          rx_idle_pct;
   logic        hold_req;
   logic        hold_rx;
   int          cycles = 0;

   mlfq_task_scheduler dut (.*);

   mlfq_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);

   initial begin
      hold_rx = 1'b0;
      wait (hold_req);
      @(posedge clock);
      hold_rx <= 1'b1;
      repeat (900) @(posedge clock);
      hold_rx <= 1'b0;
   end

   task automatic send_item(logic k, logic [3:0] s, logic [1:0] l, logic [9:0] b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_task_slot <= s;
      req_base_level <= l;
      req_burst_ticks <= b;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_random();
      logic [9:0] b;
      b = ($urandom_range(99) < 85) ? 10'($urandom_range(6, 1)) : 10'($urandom_range(1023, 1));
      if ($urandom_range(99) < 45)
         send_item(1'b0, 4'($urandom), 2'($urandom), b);
      else
         send_item(1'b1, 4'($urandom), 2'($urandom), b);
   endtask

   task automatic settle_and_write(logic [15:0] v);
      req_valid <= 1'b0;
      while (events_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_timeout_limit <= v;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_task_slot = '0;
      req_base_level = '0;
      req_burst_ticks = '0;
      csr_valid = 1'b0;
      csr_timeout_limit = '0;
      hold_req = 1'b0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      settle_and_write(mlfq_pkg::TIMEOUT_RESET);
      send_item(1'b0, 4'd0, 2'd0, 10'd2);
      send_item(1'b0, 4'd1, 2'd1, 10'd3);
      send_item(1'b0, 4'd15, 2'd2, 10'd1);
      send_item(1'b0, 4'd2, 2'd3, 10'd1023);
      send_item(1'b0, 4'd0, 2'd2, 10'd5);
      repeat (10) send_item(1'b1, 4'd15, 2'd3, 10'd1023);
      send_item(1'b0, 4'd0, 2'd0, 10'd1);
      send_item(1'b1, 4'd0, 2'd0, 10'd1);

      settle_and_write(16'd1);
      send_item(1'b0, 4'd3, 2'd0, 10'd4);
      send_item(1'b0, 4'd4, 2'd2, 10'd2);
      send_item(1'b0, 4'd5, 2'd1, 10'd2);
      repeat (4) send_item(1'b1, 4'd0, 2'd0, 10'd1);
      tx_idle_pct = 11;
      rx_idle_pct = 84;
      repeat (30) send_random();

      settle_and_write(16'hFFFF);
      tx_idle_pct = 84;
      rx_idle_pct = 11;
      repeat (30) send_random();

      settle_and_write(16'($urandom_range(30, 3)));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_req = 1'b1;
      repeat (26) send_random();
      req_valid <= 1'b0;

      while (events_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
